[rtl/core/sonar_echo_ranging_averager_macros.svh]
// Assertion macros for the sonar averager RTL.
`ifndef SONAR_ECHO_RANGING_AVERAGER_MACROS_SVH
`define SONAR_ECHO_RANGING_AVERAGER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off while rst_n is low
`define SERA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sonar averager check failed");
// next-cycle implication
`define SERA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sonar averager check failed");
`else
`define SERA_ASSERT_IMP(name, ante, cons)
`define SERA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[rtl/core/sera_pkg.sv]
package sera_pkg;

    localparam int ADDR_W  = 5;
    localparam int RPB_W   = 5;
    localparam int TRIG_W  = 8;
    localparam int TMO_W   = 16;
    localparam int PAUSE_W = 20;
    localparam int AVG_W   = 16;
    localparam int TICK_W  = 20;

    localparam logic [RPB_W-1:0]   RPB_RST   = 5'd4;
    localparam logic [TRIG_W-1:0]  TRIG_RST  = 8'd10;
    localparam logic [TMO_W-1:0]   START_RST = 16'd5000;
    localparam logic [TMO_W-1:0]   PULSE_RST = 16'd60000;
    localparam logic [AVG_W-1:0]   SAFE_RST  = 16'd1000;
    localparam logic [PAUSE_W-1:0] PAUSE_RST = 20'd100000;

    typedef enum logic [2:0] {
        REG_READINGS = 3'd0,
        REG_TRIGGER  = 3'd1,
        REG_START    = 3'd2,
        REG_PULSE    = 3'd3,
        REG_SAFE     = 3'd4,
        REG_PAUSE    = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_PAUSE = 4'b0001,
        PH_TRIG  = 4'b0010,
        PH_RISE  = 4'b0100,
        PH_MEAS  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        BK_TAKE = 2'b01,
        BK_DIV  = 2'b10
    } back_st_t;

    // per-tick control bits handed from front to back
    typedef struct packed {
        logic trig;
        logic done;
    } job_ctl_t;

    // result word, trigger_out in bit 0
    typedef struct packed {
        logic [3:0]       pad;
        logic             no_reading;
        logic [AVG_W-1:0] average_width;
        logic             burst_done;
        logic             led_out;
        logic             trigger_out;
    } out_item_t;

endpackage

[rtl/core/sera_front.sv]
module sera_front #(
    parameter int MAX_READINGS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          echo,
    input  logic [sera_pkg::RPB_W-1:0]    readings,
    input  logic [sera_pkg::TRIG_W-1:0]   trigger_ticks,
    input  logic [sera_pkg::TMO_W-1:0]    start_timeout,
    input  logic [sera_pkg::TMO_W-1:0]    pulse_timeout,
    input  logic [sera_pkg::PAUSE_W-1:0]  pause_ticks,
    output sera_pkg::job_ctl_t            job_ctl,
    output logic [sera_pkg::AVG_W+$clog2(MAX_READINGS)-1:0] job_total,
    output logic [$clog2(MAX_READINGS+1)-1:0]               job_cnt
);
    import sera_pkg::*;

    localparam int SUM_W = AVG_W + $clog2(MAX_READINGS);
    localparam int CNT_W = $clog2(MAX_READINGS + 1);
    localparam int CMP_W = (CNT_W > RPB_W) ? CNT_W : RPB_W;

    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_reg, tick_next, t_inc;
    logic [CNT_W-1:0]   idx_reg, idx_next, idx_inc;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   len;
    logic [CMP_W-1:0]   rpb_ext;
    logic               end_rd, end_ok, trig, done;

    // readings of zero act as one, above the maximum act as the maximum
    always_comb
    begin
        rpb_ext = CMP_W'(readings);
        if (readings == '0)
            len = CNT_W'(1);
        else if (rpb_ext > CMP_W'(MAX_READINGS))
            len = CNT_W'(MAX_READINGS);
        else
            len = rpb_ext[CNT_W-1:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        cnt_next   = cnt_reg;
        trig       = 1'b0;
        end_rd     = 1'b0;
        end_ok     = 1'b0;
        done       = 1'b0;
        t_inc      = tick_reg + TICK_W'(1);
        idx_inc    = idx_reg + CNT_W'(1);

        unique case (phase_reg)
            PH_PAUSE:
            begin
                if (tick_reg >= pause_ticks)
                begin
                    phase_next = PH_TRIG;
                    tick_next  = '0;
                    idx_next   = '0;
                    total_next = '0;
                    cnt_next   = '0;
                end
                else
                    tick_next = t_inc;
            end
            PH_TRIG:
            begin
                trig = 1'b1;
                if (t_inc >= TICK_W'(trigger_ticks))
                begin
                    phase_next = PH_RISE;
                    tick_next  = '0;
                end
                else
                    tick_next = t_inc;
            end
            PH_RISE:
            begin
                if (echo)
                begin
                    // rise tick already counts as one high tick
                    phase_next = PH_MEAS;
                    tick_next  = TICK_W'(1);
                    if (pulse_timeout == '0)
                        end_rd = 1'b1;
                end
                else
                begin
                    tick_next = t_inc;
                    if (t_inc > TICK_W'(start_timeout))
                        end_rd = 1'b1;
                end
            end
            PH_MEAS:
            begin
                if (!echo)
                begin
                    end_rd = 1'b1;
                    end_ok = 1'b1;
                end
                else
                begin
                    tick_next = t_inc;
                    if (t_inc > TICK_W'(pulse_timeout))
                        end_rd = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_PAUSE;
                tick_next  = '0;
            end
        endcase

        if (end_rd)
        begin
            if (end_ok)
            begin
                // high count never exceeds the 16-bit pulse timeout here
                total_next = total_reg + SUM_W'(tick_reg[AVG_W-1:0]);
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            idx_next  = idx_inc;
            tick_next = '0;
            if (idx_inc >= len)
            begin
                phase_next = PH_PAUSE;
                done       = 1'b1;
            end
            else
                phase_next = PH_TRIG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PAUSE;
            tick_reg  <= '0;
            idx_reg   <= '0;
            total_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign job_ctl.trig = trig;
    assign job_ctl.done = done;
    assign job_total    = total_next;
    assign job_cnt      = cnt_next;

endmodule

[rtl/core/sera_queue.sv]
module sera_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign rvalid  = (count_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[rtl/core/sera_div.sv]
module sera_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [DEN_W:0]    shifted, diff;
    logic              ge;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
                busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

[rtl/core/sera_back.sv]
module sera_back #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  sera_pkg::job_ctl_t           job_ctl,
    input  logic [SUM_W-1:0]             job_total,
    input  logic [CNT_W-1:0]             job_cnt,
    output logic                         q_pop,
    input  logic [sera_pkg::AVG_W-1:0]   safe_width,
    output logic                         div_start,
    output logic [SUM_W-1:0]             div_num,
    output logic [CNT_W-1:0]             div_den,
    input  logic                         div_busy,
    input  logic [SUM_W-1:0]             div_quo,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output sera_pkg::out_item_t          m_item
);
    import sera_pkg::*;

    back_st_t         st_reg, st_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             led_reg, led_next;
    logic             trig_hold_reg;
    logic             out_free, load;
    logic [AVG_W-1:0] avg;

    assign out_free = !out_valid_reg || m_tready;
    assign avg      = div_quo[AVG_W-1:0];
    assign div_num  = job_total;
    assign div_den  = job_cnt;

    always_comb
    begin
        st_next   = st_reg;
        led_next  = led_reg;
        out_next  = out_reg;
        q_pop     = 1'b0;
        div_start = 1'b0;
        load      = 1'b0;

        unique case (st_reg)
            BK_TAKE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (job_ctl.done && job_cnt != '0)
                    begin
                        div_start = 1'b1;
                        st_next   = BK_DIV;
                    end
                    else
                    begin
                        load                   = 1'b1;
                        out_next.pad           = '0;
                        out_next.trigger_out   = job_ctl.trig;
                        out_next.led_out       = led_reg;
                        out_next.burst_done    = job_ctl.done;
                        out_next.average_width = '0;
                        out_next.no_reading    = job_ctl.done;
                    end
                end
            end
            BK_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    load                   = 1'b1;
                    led_next               = (avg < safe_width);
                    out_next.pad           = '0;
                    out_next.trigger_out   = trig_hold_reg;
                    out_next.led_out       = led_next;
                    out_next.burst_done    = 1'b1;
                    out_next.average_width = avg;
                    out_next.no_reading    = 1'b0;
                    st_next                = BK_TAKE;
                end
            end
            default:
            begin
                st_next = BK_TAKE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
        if (div_start)
            trig_hold_reg <= job_ctl.trig;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_TAKE;
            out_valid_reg <= 1'b0;
            led_reg       <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            led_reg       <= led_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_item   = out_reg;

endmodule

[rtl/core/sonar_echo_ranging_averager.sv]
// Sonar echo ranging averager. Each input request is one microsecond tick with the
// sampled echo level in s_tdata[0]; each tick yields exactly one result request
// with the trigger drive, the LED drive, and on the tick a burst closes the mean
// echo width (or a no-reading flag). A front FSM tracks pause, trigger, rise and
// measure phases and accumulates widths, one tick per clock while the queue is
// not full; it hands a small job word per tick into a two-entry queue. The back
// end drains the queue into a registered output stage. Ordinary ticks pass at
// one per clock unless m_tready holds the output or a division runs. The tick
// that closes a burst with valid readings runs a restoring divider at one
// quotient bit per clock; the queue keeps accepting ticks meanwhile and s_tready
// drops only once it fills. Registers (APB, 32-bit, byte address 4*i, written
// when psel, penable, pwrite and pready are high, pready tied high):
// 0 readings_per_burst, 1 trigger_ticks, 2 start_timeout, 3 pulse_timeout,
// 4 safe_width, 5 pause_ticks. Write them only while no tick is in flight.
`include "sonar_echo_ranging_averager_macros.svh"

module sonar_echo_ranging_averager #(
    parameter int MAX_READINGS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave side: tdata[0] echo_level, tdata[7:1] zero
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    // master side: tdata[0] trigger_out, [1] led_out, [2] burst_done,
    // [18:3] average_width, [19] no_reading, [23:20] zero
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sera_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sera_pkg::*;

    localparam int SUM_W   = AVG_W + $clog2(MAX_READINGS);
    localparam int CNT_W   = $clog2(MAX_READINGS + 1);
    localparam int JOB_W   = $bits(job_ctl_t) + SUM_W + CNT_W;
    localparam int Q_DEPTH = 2;

    // configuration registers
    logic [RPB_W-1:0]   rpb_reg;
    logic [TRIG_W-1:0]  trig_reg;
    logic [TMO_W-1:0]   start_reg;
    logic [TMO_W-1:0]   pulse_reg;
    logic [AVG_W-1:0]   safe_reg;
    logic [PAUSE_W-1:0] pause_reg;
    reg_idx_t           reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpb_reg   <= RPB_RST;
            trig_reg  <= TRIG_RST;
            start_reg <= START_RST;
            pulse_reg <= PULSE_RST;
            safe_reg  <= SAFE_RST;
            pause_reg <= PAUSE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_READINGS: rpb_reg   <= pwdata[RPB_W-1:0];
                REG_TRIGGER:  trig_reg  <= pwdata[TRIG_W-1:0];
                REG_START:    start_reg <= pwdata[TMO_W-1:0];
                REG_PULSE:    pulse_reg <= pwdata[TMO_W-1:0];
                REG_SAFE:     safe_reg  <= pwdata[AVG_W-1:0];
                REG_PAUSE:    pause_reg <= pwdata[PAUSE_W-1:0];
                default:      ;  // unmapped, ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_READINGS: prdata = 32'(rpb_reg);
            REG_TRIGGER:  prdata = 32'(trig_reg);
            REG_START:    prdata = 32'(start_reg);
            REG_PULSE:    prdata = 32'(pulse_reg);
            REG_SAFE:     prdata = 32'(safe_reg);
            REG_PAUSE:    prdata = 32'(pause_reg);
            default:      prdata = '0;
        endcase
    end

    // front: phase tracking and accumulation, one tick per accepted request
    job_ctl_t         f_ctl;
    logic [SUM_W-1:0] f_total;
    logic [CNT_W-1:0] f_cnt;
    logic             q_full;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    sera_front #(
        .MAX_READINGS (MAX_READINGS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .echo          (s_tdata[0]),
        .readings      (rpb_reg),
        .trigger_ticks (trig_reg),
        .start_timeout (start_reg),
        .pulse_timeout (pulse_reg),
        .pause_ticks   (pause_reg),
        .job_ctl       (f_ctl),
        .job_total     (f_total),
        .job_cnt       (f_cnt)
    );

    // job queue between front and back
    logic [JOB_W-1:0] q_wdata, q_rdata;
    logic             q_valid, q_pop;
    job_ctl_t         b_ctl;
    logic [SUM_W-1:0] b_total;
    logic [CNT_W-1:0] b_cnt;

    assign q_wdata                 = {f_ctl, f_total, f_cnt};
    assign {b_ctl, b_total, b_cnt} = q_rdata;

    sera_queue #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    // back: burst mean through the single divider, output register
    logic             div_start, div_busy;
    logic [SUM_W-1:0] div_num, div_quo;
    logic [CNT_W-1:0] div_den;
    out_item_t        out_item;

    sera_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    sera_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .job_ctl    (b_ctl),
        .job_total  (b_total),
        .job_cnt    (b_cnt),
        .q_pop      (q_pop),
        .safe_width (safe_reg),
        .div_start  (div_start),
        .div_num    (div_num),
        .div_den    (div_den),
        .div_busy   (div_busy),
        .div_quo    (div_quo),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_item     (out_item)
    );

    assign m_tdata = out_item;

    // back end holds the queue while a mean is being computed
    `SERA_ASSERT_IMP(a_div_holds_queue, div_busy, !q_pop)
    // a started division is in flight on the next clock
    `SERA_ASSERT_NEXT(a_div_runs, div_start, div_busy)
    // bursts never close on a trigger tick
    `SERA_ASSERT_IMP(a_no_trig_at_end, m_tvalid && out_item.burst_done, !out_item.trigger_out)
    // no-reading results carry a zero mean and mark the burst end
    `SERA_ASSERT_IMP(a_none_is_end, m_tvalid && out_item.no_reading, out_item.burst_done && out_item.average_width == '0)

endmodule
